// ----- rtl/core/jseu_pkg.sv -----
// Package for the JSON string escaper: word types for both channels and the
// job word passed from the classifier to the character generator.
// No dependencies.
`timescale 1ns / 1ps

package jseu_pkg;

    // one string byte in
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    // one escaped character out
    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
        logic       out_error;
    } t_out_word;

    // job kinds
    localparam logic [1:0] JOB_CHAR = 2'd0;  // pass one byte through
    localparam logic [1:0] JOB_ESC  = 2'd1;  // backslash and one letter
    localparam logic [1:0] JOB_ERR  = 2'd2;  // string ended mid sequence
    localparam logic [1:0] JOB_UNI  = 2'd3;  // one or two \uXXXX units

    typedef struct packed {
        logic [1:0]  kind;
        logic        two_units;
        logic [15:0] unit0;   // also holds the byte or escape letter
        logic [15:0] unit1;
    } t_job;

endpackage

// ----- rtl/core/json_string_escaper_utf16.sv -----
// Top level of the JSON string escaper with UTF-8 to UTF-16 conversion.
// Depends on jseu_pkg, jseu_front, jseu_queue and jseu_back.
`timescale 1ns / 1ps
//
//  channel   direction  handshake           word
//  -------   ---------  ------------------  ---------------------------------
//  bytes     in         push / full         i_data: in_byte, in_last
//  chars     out        pop / empty         o_data: out_char, out_last,
//                                                   out_error
//
// One byte is taken per cycle while full is low. Each byte turns into zero to
// twelve characters: plain bytes one, escapes two, each \uXXXX unit six. The
// character generator writes one character per cycle into the output
// register while that register is free or being popped, so the output port
// sets the throughput. The first character of a byte passes through the job
// queue and then the output register before it appears on the output. Reset
// is synchronous and clears the sequence tracker, the job queue and the
// output register's valid flag. Either side may stall on its own: the job
// queue holds up to QUEUE_DEPTH job words.

module json_string_escaper_utf16 import jseu_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_word  i_data,
    input  logic      pop,
    output logic      empty,
    output t_out_word o_data
);

    logic      accept;
    t_job      front_job;
    logic      front_job_vld;
    logic      mid_seq;
    logic      q_full;
    t_job      q_job;
    logic      q_vld;
    logic      q_pop;
    logic      out_vld;

    // take a byte whenever the job queue has room
    assign full   = q_full;
    assign accept = push & ~q_full;

    jseu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_word    (i_data),
        .o_job     (front_job),
        .o_job_vld (front_job_vld),
        .o_mid_seq (mid_seq)
    );

    jseu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_job_vld),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_vld   (q_vld)
    );

    jseu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (q_job),
        .i_job_vld (q_vld),
        .o_job_pop (q_pop),
        .i_out_pop (pop),
        .o_out_vld (out_vld),
        .o_word    (o_data)
    );

    // present the output register as the head of the result queue
    assign empty = ~out_vld;

`ifndef SYNTHESIS
    // the end of a string always leaves the sequence tracker idle
    a_last_clears_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_data.in_last |=> !mid_seq)
        else $error("sequence state survived the last byte");

    // an error word is a lone zero character closing its byte
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_data.out_error |-> o_data.out_last && o_data.out_char == 8'h00)
        else $error("malformed error word");

    // nothing is shown right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("output not empty after reset");
`endif

endmodule

// ----- rtl/core/jseu_front.sv -----
// Front end: accepts string bytes, tracks UTF-8 sequences and classifies
// each byte into a job word. Depends on jseu_pkg.
`timescale 1ns / 1ps

module jseu_front import jseu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_word i_word,
    output t_job     o_job,
    output logic     o_job_vld,
    output logic     o_mid_seq
);

    localparam logic [31:0] SHORT_LIMIT = 32'h00EF_BFBF;
    localparam logic [31:0] MASK_NARROW = 32'h000F_0000;
    localparam logic [31:0] MASK_WIDE   = 32'h003F_0000;
    localparam logic [31:0] MASK_TOP    = 32'h0700_0000;
    localparam logic [31:0] MASK_MID    = 32'h0000_3F00;
    localparam logic [31:0] MASK_LOW    = 32'h0000_003F;
    localparam logic [15:0] HI_SURR     = 16'hD800;
    localparam logic [15:0] LO_SURR     = 16'hDC00;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [7:0]  LEAD_MASK   = 8'hC0;

    logic [31:0] r_seq, n_seq;
    logic [1:0]  r_left, n_left;
    logic [2:0]  r_len, n_len;

    logic [7:0]  b;
    logic [31:0] shifted;
    logic [31:0] m;
    logic [31:0] cp32;
    logic [20:0] cp;
    logic [20:0] t;
    logic [2:0]  lead_len;
    logic [7:0]  esc;
    logic        complete;
    t_job        job;
    logic        job_vld;

    always_comb begin
        b        = i_word.in_byte;
        shifted  = {r_seq[23:0], b};
        m        = (shifted <= SHORT_LIMIT) ? MASK_NARROW : MASK_WIDE;
        cp32     = ((shifted & MASK_TOP) >> 6) | ((shifted & m) >> 4)
                 | ((shifted & MASK_MID) >> 2) | (shifted & MASK_LOW);
        cp       = cp32[20:0];
        t        = cp - SUPP_BASE;
        lead_len = (b >= 8'hF0) ? 3'd4 : ((b >= 8'hE0) ? 3'd3 : 3'd2);
        esc      = 8'h00;
        complete = 1'b0;
        n_seq    = r_seq;
        n_left   = r_left;
        n_len    = r_len;
        job      = '0;
        job_vld  = 1'b0;

        if (r_left != 2'd0) begin
            n_seq  = shifted;
            n_left = r_left - 2'd1;
            if (n_left == 2'd0) begin
                complete = 1'b1;
            end
        end else if ((b & LEAD_MASK) == LEAD_MASK) begin
            n_seq  = {24'd0, b};
            n_len  = lead_len;
            n_left = 2'(lead_len - 3'd1);
        end else begin
            case (b)
                8'h22:   esc = 8'h22;  // quote
                8'h5C:   esc = 8'h5C;  // backslash
                8'h2F:   esc = 8'h2F;  // slash
                8'h08:   esc = 8'h62;  // b
                8'h0C:   esc = 8'h66;  // f
                8'h0A:   esc = 8'h6E;  // n
                8'h0D:   esc = 8'h72;  // r
                8'h09:   esc = 8'h74;  // t
                default: esc = 8'h00;
            endcase
            job_vld = 1'b1;
            if (esc != 8'h00) begin
                job.kind  = JOB_ESC;
                job.unit0 = {8'd0, esc};
            end else begin
                job.kind  = JOB_CHAR;
                job.unit0 = {8'd0, b};
            end
        end

        if (complete) begin
            job_vld  = 1'b1;
            job.kind = JOB_UNI;
            if (r_len == 3'd4) begin
                job.two_units = 1'b1;
                if (cp < SUPP_BASE) begin
                    // overlong: zero unit, then the plain code point
                    job.unit0 = 16'd0;
                    job.unit1 = cp[15:0];
                end else begin
                    job.unit0 = HI_SURR + {6'd0, t[19:10]};
                    job.unit1 = LO_SURR + {6'd0, t[9:0]};
                end
            end else if (r_len == 3'd3 && cp[20:16] != 5'd0) begin
                job.two_units = 1'b1;
                job.unit0     = {11'd0, cp[20:16]};
                job.unit1     = cp[15:0];
            end else begin
                job.unit0 = cp[15:0];
            end
        end

        // string ended inside a sequence: the error word replaces all else
        if (i_word.in_last && n_left != 2'd0) begin
            job_vld  = 1'b1;
            job      = '0;
            job.kind = JOB_ERR;
        end

        if (i_word.in_last) begin
            n_seq  = '0;
            n_left = '0;
            n_len  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq  <= '0;
            r_left <= '0;
            r_len  <= '0;
        end else if (i_accept) begin
            r_seq  <= n_seq;
            r_left <= n_left;
            r_len  <= n_len;
        end
    end

    assign o_job     = job;
    assign o_job_vld = i_accept & job_vld;
    assign o_mid_seq = (r_left != 2'd0);

endmodule

// ----- rtl/core/jseu_queue.sv -----
// Short job queue between the front end and the character generator.
// Depends on jseu_pkg.
`timescale 1ns / 1ps

module jseu_queue import jseu_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_vld
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_vld   = (r_cnt != '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_vld;
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ----- rtl/core/jseu_back.sv -----
// Back end: expands one job word into output characters, one per cycle while
// the registered output stage is free or being popped. Depends on jseu_pkg.
`timescale 1ns / 1ps

module jseu_back import jseu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  logic      i_job_vld,
    output logic      o_job_pop,
    input  logic      i_out_pop,
    output logic      o_out_vld,
    output t_out_word o_word
);

    localparam logic [2:0] POS_BSL  = 3'd0;
    localparam logic [2:0] POS_U    = 3'd1;
    localparam logic [2:0] POS_HEX3 = 3'd2;
    localparam logic [2:0] POS_HEX2 = 3'd3;
    localparam logic [2:0] POS_HEX1 = 3'd4;
    localparam logic [2:0] POS_HEX0 = 3'd5;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        hex_char = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
    endfunction

    logic [2:0]  r_pos, n_pos;
    logic        r_unit, n_unit;
    logic        r_out_vld;
    t_out_word   r_word;

    logic        advance;
    logic [15:0] unit;
    logic [3:0]  nib;
    t_out_word   word;

    assign advance = i_job_vld & (~r_out_vld | i_out_pop);
    assign unit    = r_unit ? i_job.unit1 : i_job.unit0;

    always_comb begin
        case (r_pos)
            POS_HEX3: nib = unit[15:12];
            POS_HEX2: nib = unit[11:8];
            POS_HEX1: nib = unit[7:4];
            default:  nib = unit[3:0];
        endcase

        word  = '0;
        n_pos = r_pos;
        n_unit = r_unit;
        case (i_job.kind)
            JOB_CHAR: begin
                word.out_char = i_job.unit0[7:0];
                word.out_last = 1'b1;
            end
            JOB_ESC: begin
                word.out_char = (r_pos == POS_BSL) ? 8'h5C : i_job.unit0[7:0];
                word.out_last = (r_pos != POS_BSL);
            end
            JOB_ERR: begin
                word.out_last  = 1'b1;
                word.out_error = 1'b1;
            end
            default: begin
                case (r_pos)
                    POS_BSL: word.out_char = 8'h5C;
                    POS_U:   word.out_char = 8'h75;
                    default: word.out_char = hex_char(nib);
                endcase
                word.out_last = (r_pos == POS_HEX0) & (r_unit | ~i_job.two_units);
            end
        endcase

        // step through the job; drop back to the start after each unit and once the job is done
        if (word.out_last) begin
            n_pos  = POS_BSL;
            n_unit = 1'b0;
        end else if (r_pos == POS_HEX0) begin
            n_pos  = POS_BSL;
            n_unit = 1'b1;
        end else begin
            n_pos = r_pos + 3'd1;
        end
    end

    assign o_job_pop = advance & word.out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_BSL;
            r_unit    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (advance) begin
                r_pos     <= n_pos;
                r_unit    <= n_unit;
                r_out_vld <= 1'b1;
            end else if (i_out_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_word <= word;
        end
    end

    assign o_out_vld = r_out_vld;
    assign o_word    = r_word;

endmodule
